[hdl/text_console_writer_macros.svh]
// assertion macros for the console writer checker
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// condition holds in the same cycle
`define TCW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition holds in the following cycle
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/tcw_pkg.sv]
package tcw_pkg;

  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int CELL_W      = 16;
  localparam int COL_W       = 7;
  localparam int ROW_OUT_W   = 5;
  localparam int LINES_W     = 5;
  localparam int INDEX_W     = 11;
  localparam int COLOUR_W    = 4;
  localparam int CMD_W       = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 4;
  localparam int TAB_STEP    = 4;

  localparam logic [CHAR_W-1:0]   TAB_CODE       = 8'h09;
  localparam logic [CHAR_W-1:0]   NEWLINE_CODE   = 8'h0A;
  localparam logic [CHAR_W-1:0]   BLANK_CHAR     = 8'h00;
  localparam logic [COLOUR_W-1:0] DEFAULT_FG_RST = 4'hF;
  localparam logic [COLOUR_W-1:0] DEFAULT_BG_RST = 4'h7;

  localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_FG = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_BG = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT,
    CMD_CLEAR,
    CMD_SCROLL,
    CMD_READ
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUT,
    OP_TAB,
    OP_NL,
    OP_CLEAR,
    OP_SCROLL,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic [CHAR_W-1:0]    ch;
    logic [ATTR_W-1:0]    attr;
    logic [LINES_W-1:0]   lines;
    logic [INDEX_W-1:0]   index;
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_BLANK
  } back_state_t;

endpackage

[hdl/text_console_writer.sv]
// put, tab, newline and out-of-range reads give their result in the cycle after
//   leaving the queue; reads pass the store's read register, then the result register;
//   one put, tab, newline or out-of-range read per cycle while the output is not stalled
// scroll, clear, and a put, tab or newline past the last row walk the whole screen store
// reset: synchronous, active low; then a clearing pass over all ROWS*COLUMNS cells
//   blanks the store before the first item is carried out
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [tcw_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tcw_pkg::CMD_W-1:0]         in_command,
  input  logic [tcw_pkg::CHAR_W-1:0]        in_char_code,
  input  logic [tcw_pkg::COLOUR_W-1:0]      in_fg_colour,
  input  logic [tcw_pkg::COLOUR_W-1:0]      in_bg_colour,
  input  logic [tcw_pkg::LINES_W-1:0]       in_scroll_lines,
  input  logic [tcw_pkg::INDEX_W-1:0]       in_cell_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tcw_pkg::CHAR_W-1:0]        out_read_char,
  output logic [tcw_pkg::ATTR_W-1:0]        out_read_attr,
  output logic [tcw_pkg::COL_W-1:0]         out_cursor_col,
  output logic [tcw_pkg::ROW_OUT_W-1:0]     out_cursor_row
);
  import tcw_pkg::*;

  logic [COLOUR_W-1:0] default_fg_r;
  logic [COLOUR_W-1:0] default_bg_r;
  logic                q_valid;
  logic                q_pop;
  op_t                 q_op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_fg_r <= DEFAULT_FG_RST;
      default_bg_r <= DEFAULT_BG_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DEFAULT_FG: default_fg_r <= cfg_wdata;
        REG_DEFAULT_BG: default_bg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_char_code    (in_char_code),
    .in_fg_colour    (in_fg_colour),
    .in_bg_colour    (in_bg_colour),
    .in_scroll_lines (in_scroll_lines),
    .in_cell_index   (in_cell_index),
    .q_valid         (q_valid),
    .q_op            (q_op),
    .q_pop           (q_pop)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_op           (q_op),
    .q_pop          (q_pop),
    .cfg_blank      ({default_bg_r, default_fg_r}),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_char  (out_read_char),
    .out_read_attr  (out_read_attr),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row)
  );

endmodule

[hdl/tcw_front.sv]
module tcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tcw_pkg::CMD_W-1:0]     in_command,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcw_pkg::COLOUR_W-1:0]  in_fg_colour,
  input  logic [tcw_pkg::COLOUR_W-1:0]  in_bg_colour,
  input  logic [tcw_pkg::LINES_W-1:0]   in_scroll_lines,
  input  logic [tcw_pkg::INDEX_W-1:0]   in_cell_index,
  output logic                          q_valid,
  output tcw_pkg::op_t                  q_op,
  input  logic                          q_pop
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  op_t        op_in;
  op_t        q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;

  // classify the incoming item
  always_comb begin
    op_in.ch    = in_char_code;
    op_in.attr  = {in_bg_colour, in_fg_colour};
    op_in.lines = in_scroll_lines;
    op_in.index = in_cell_index;
    case (cmd_t'(in_command))
      CMD_PUT: begin
        if (in_char_code == TAB_CODE) begin
          op_in.kind = OP_TAB;
        end else if (in_char_code == NEWLINE_CODE) begin
          op_in.kind = OP_NL;
        end else begin
          op_in.kind = OP_PUT;
        end
      end
      CMD_CLEAR: begin
        op_in.kind = OP_CLEAR;
      end
      CMD_SCROLL: begin
        if (in_scroll_lines == '0) begin
          op_in.kind = OP_NOP;
        end else if (32'(in_scroll_lines) >= ROWS) begin
          op_in.kind = OP_CLEAR;
        end else begin
          op_in.kind = OP_SCROLL;
        end
      end
      CMD_READ: begin
        op_in.kind = (32'(in_cell_index) < CELLS) ? OP_READ : OP_NOP;
      end
      default: begin
        op_in.kind = OP_NOP;
      end
    endcase
  end

  // two-entry queue toward the back end
  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_op     = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

[hdl/tcw_back.sv]
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  tcw_pkg::op_t                   q_op,
  output logic                           q_pop,
  input  logic [tcw_pkg::ATTR_W-1:0]     cfg_blank,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tcw_pkg::CHAR_W-1:0]     out_read_char,
  output logic [tcw_pkg::ATTR_W-1:0]     out_read_attr,
  output logic [tcw_pkg::COL_W-1:0]      out_cursor_col,
  output logic [tcw_pkg::ROW_OUT_W-1:0]  out_cursor_row
);
  import tcw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int ROW_W  = $clog2(ROWS);

  logic [CELL_W-1:0] cells_mem [CELLS];
  logic [CELL_W-1:0] rd_data_r;

  back_state_t       state_r, state_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [CNT_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [ATTR_W-1:0] blank_r, blank_nxt;
  logic              send_r, send_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic [ATTR_W-1:0]    out_attr_r, out_attr_nxt;
  logic [COL_W-1:0]     out_col_r;
  logic [ROW_OUT_W-1:0] out_row_r;
  logic                 load_out;

  logic                 mem_we, mem_re;
  logic [ADDR_W-1:0]    mem_wa, mem_ra;
  logic [CELL_W-1:0]    mem_wd;

  logic                        out_free, take, wrap, last_row, rd_more, blank_last;
  logic [COL_W:0]              col_sum;
  logic [ADDR_W-1:0]           cur_addr;
  logic [ADDR_W+INDEX_W-1:0]   idx_ext;
  logic [ROW_W+ROW_OUT_W-1:0]  row_ext;

  assign out_free   = !out_valid_r || out_ready;
  assign take       = (state_r == ST_IDLE) && q_valid && out_free;
  assign col_sum    = {1'b0, cur_col_r}
                      + ((q_op.kind == OP_TAB) ? (COL_W+1)'(TAB_STEP) : (COL_W+1)'(1));
  assign wrap       = (q_op.kind == OP_NL) || (32'(col_sum) >= COLUMNS);
  assign last_row   = (32'(cur_row_r) == ROWS - 1);
  assign cur_addr   = ADDR_W'(32'(cur_row_r) * COLUMNS + 32'(cur_col_r));
  assign idx_ext    = {{ADDR_W{1'b0}}, q_op.index};
  assign rd_more    = (32'(rd_ptr_r) < CELLS);
  assign blank_last = (32'(wr_ptr_r) == CELLS - 1);
  assign row_ext    = {{ROW_OUT_W{1'b0}}, cur_row_nxt};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          case (q_op.kind)
            OP_READ:   state_nxt = ST_READ;
            OP_CLEAR:  state_nxt = ST_BLANK;
            OP_SCROLL: state_nxt = ST_COPY;
            OP_PUT, OP_TAB, OP_NL: begin
              if (wrap && last_row) begin
                state_nxt = ST_COPY;
              end
            end
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      ST_COPY: begin
        if (!rd_more && !rd_vld_r) begin
          state_nxt = ST_BLANK;
        end
      end
      ST_BLANK: begin
        if (blank_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    q_pop        = take;
    mem_we       = 1'b0;
    mem_wa       = wr_ptr_r[ADDR_W-1:0];
    mem_wd       = {blank_r, BLANK_CHAR};
    mem_re       = 1'b0;
    mem_ra       = rd_ptr_r[ADDR_W-1:0];
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    rd_vld_nxt   = 1'b0;
    blank_nxt    = blank_r;
    send_nxt     = send_r;
    load_out     = 1'b0;
    out_char_nxt = '0;
    out_attr_nxt = '0;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          case (q_op.kind)
            OP_PUT, OP_TAB, OP_NL: begin
              if (q_op.kind == OP_PUT) begin
                mem_we = 1'b1;
                mem_wa = cur_addr;
                mem_wd = {q_op.attr, q_op.ch};
              end
              if (wrap) begin
                cur_col_nxt = '0;
                if (last_row) begin
                  // ran off the bottom: scroll one row, cursor stays on last row
                  rd_ptr_nxt = CNT_W'(COLUMNS);
                  wr_ptr_nxt = '0;
                  blank_nxt  = cfg_blank;
                  send_nxt   = 1'b1;
                end else begin
                  cur_row_nxt = cur_row_r + ROW_W'(1);
                  load_out    = 1'b1;
                end
              end else begin
                cur_col_nxt = col_sum[COL_W-1:0];
                load_out    = 1'b1;
              end
            end
            OP_READ: begin
              mem_re = 1'b1;
              mem_ra = idx_ext[ADDR_W-1:0];
            end
            OP_CLEAR: begin
              wr_ptr_nxt  = '0;
              blank_nxt   = cfg_blank;
              send_nxt    = 1'b1;
              cur_col_nxt = '0;
              cur_row_nxt = '0;
            end
            OP_SCROLL: begin
              rd_ptr_nxt = CNT_W'(32'(q_op.lines) * COLUMNS);
              wr_ptr_nxt = '0;
              blank_nxt  = cfg_blank;
              send_nxt   = 1'b1;
              if (32'(q_op.lines) > 32'(cur_row_r)) begin
                cur_row_nxt = '0;
              end else begin
                cur_row_nxt = cur_row_r - ROW_W'(q_op.lines);
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        load_out     = 1'b1;
        out_char_nxt = rd_data_r[CHAR_W-1:0];
        out_attr_nxt = rd_data_r[CELL_W-1:CHAR_W];
      end
      ST_COPY: begin
        if (rd_more) begin
          mem_re     = 1'b1;
          rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          mem_we     = 1'b1;
          mem_wd     = rd_data_r;
          wr_ptr_nxt = wr_ptr_r + CNT_W'(1);
        end
      end
      ST_BLANK: begin
        mem_we     = 1'b1;
        wr_ptr_nxt = wr_ptr_r + CNT_W'(1);
        if (blank_last) begin
          load_out = send_r;
        end
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  assign out_valid_nxt = load_out || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_BLANK;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      rd_vld_r    <= 1'b0;
      blank_r     <= {DEFAULT_BG_RST, DEFAULT_FG_RST};
      send_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      blank_r     <= blank_nxt;
      send_r      <= send_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_char_r <= out_char_nxt;
      out_attr_r <= out_attr_nxt;
      out_col_r  <= cur_col_nxt;
      out_row_r  <= row_ext[ROW_OUT_W-1:0];
    end
  end

  // screen store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= cells_mem[mem_ra];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_char  = out_char_r;
  assign out_read_attr  = out_attr_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;

endmodule

[hdl/tcw_checker.sv]
`include "text_console_writer_macros.svh"

module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 24
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [tcw_pkg::CHAR_W-1:0]        out_read_char,
  input logic [tcw_pkg::ATTR_W-1:0]        out_read_attr,
  input logic [tcw_pkg::COL_W-1:0]         out_cursor_col,
  input logic [tcw_pkg::ROW_OUT_W-1:0]     out_cursor_row
);

  // a stalled result holds its payload
  `TCW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_read_char) && $stable(out_read_attr) && $stable(out_cursor_col) && $stable(out_cursor_row), "result changed while stalled")

  // a valid result never puts the cursor off the screen
  `TCW_ASSERT_NOW(a_cursor_range, clk, rst_n, out_valid, (32'(out_cursor_col) < COLUMNS) && (32'(out_cursor_row) < ROWS), "cursor outside the screen")

  // nothing comes out right after reset, the store is still being cleared
  `TCW_ASSERT_NOW(a_quiet_after_reset, clk, rst_n, $past(!rst_n), !out_valid, "result during clearing pass")

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_read_char  (out_read_char),
  .out_read_attr  (out_read_attr),
  .out_cursor_col (out_cursor_col),
  .out_cursor_row (out_cursor_row)
);
